// ===== rtl/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS byte stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzsd_pkg;

   // History window: the 12-bit distance field fixes it at 4 KiB
   localparam int unsigned WIN_SIZE = 4096;
   localparam int unsigned WIN_AW   = $clog2(WIN_SIZE);
   localparam int unsigned FILL_W   = WIN_AW + 1;

   // Output byte counter and limit
   localparam int unsigned COUNT_W     = 24;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 24'h001000;

   // Token layout
   localparam int unsigned RUN_W  = 5;
   localparam logic [RUN_W-1:0] RUN_MIN = 5'd3;

   // Register map
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_ORDER = 2'd1;

   // Configuration seen by the engine
   typedef struct packed {
      logic [COUNT_W-1:0] out_limit;
      logic               big_endian;
   } cfg_type;

   // Access request from the engine to the window memory
   typedef struct packed {
      logic              rd_en;
      logic [WIN_AW-1:0] rd_addr;
      logic              wr_en;
      logic [WIN_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
   } win_req_type;

endpackage

`default_nettype wire

// ===== rtl/lzss_byte_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_byte_stream_decompressor
// LZSS decompressor with a 4 KiB history window and register port.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one compressed byte per request, tlast on the final byte of a
//            stream. Parser state and byte count restart after that byte.
//   rsp_*  : decompressed bytes, any number per request; tlast marks the last byte a
//            request produced, tuser flags that the byte count hit out_limit.
//   csr_*  : register writes (index 0 out_limit, index 1 token byte order),
//            always ready; write only while the block is idle.
// Timing:
//   A literal appears on rsp in the cycle after it is accepted. A match of N
//   bytes (3 to 18) holds the input after its second token byte: first a
//   window read, then one byte per cycle while the receiver takes them,
//   paced by the single read port of the window memory.
//   req_tready needs a free output register, so a stalled receiver stalls
//   the input and freezes a running copy without losing a byte.
// Reset:
//   Synchronous. The window reads as zero until written, tracked by a fill
//   count, so no clearing pass is needed and the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_byte_stream_decompressor (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // [7:0] in_byte
   input  wire logic                             req_tlast,  // stream_last
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [7:0]                            rsp_tdata,  // [7:0] out_byte
   output logic                                  rsp_tlast,  // run_last
   output logic                                  rsp_tuser,  // [0] limit_reached
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lzsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lzsd_pkg::COUNT_W-1:0]     csr_wdata
);

   logic [lzsd_pkg::COUNT_W-1:0] out_limit_ff, out_limit_in;
   logic                         token_be_ff, token_be_in;
   lzsd_pkg::cfg_type            cfg;
   lzsd_pkg::win_req_type        win_req;
   logic [7:0]                   win_rdata;

   assign csr_ready = 1'b1;

   // Register decode
   always_comb begin
      out_limit_in = out_limit_ff;
      token_be_in  = token_be_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lzsd_pkg::CSR_OUT_LIMIT:   out_limit_in = csr_wdata;
            lzsd_pkg::CSR_TOKEN_ORDER: token_be_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= lzsd_pkg::LIMIT_RESET;
         token_be_ff  <= 1'b0;
      end else begin
         out_limit_ff <= out_limit_in;
         token_be_ff  <= token_be_in;
      end
   end

   assign cfg.out_limit  = out_limit_ff;
   assign cfg.big_endian = token_be_ff;

   lzsd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .win_req    (win_req),
      .win_rdata  (win_rdata)
   );

   lzsd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .win_req (win_req),
      .rd_data (win_rdata)
   );

`ifndef ASSERT_OFF
   // input is only taken when the result register can accept a byte
   a_ready_needs_slot: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("input accepted while result register blocked");

   // the byte that reaches the limit always closes its run
   a_limit_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("limit reached without end of run");

   // every window write is a byte handed to the result register
   a_write_gives_result: assert property (@(posedge clock) disable iff (reset)
      win_req.wr_en |=> rsp_tvalid)
      else $error("window write without result");
`endif

endmodule

`default_nettype wire

// ===== rtl/lzsd_window.sv =====
// ----------------------------------------------------------------------------
// lzsd_window
// 4 KiB history window: one write and one registered read per cycle, with
// write-to-read forwarding and a fill count that makes never-written entries
// read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsd_window (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lzsd_pkg::win_req_type win_req,
   output logic [7:0]                rd_data
);

   logic [7:0] mem_array [lzsd_pkg::WIN_SIZE];

   logic [7:0]                  rdata_ff;
   logic [7:0]                  fwd_data_ff;
   logic                        fwd_ff;
   logic                        zero_ff;
   logic [lzsd_pkg::FILL_W-1:0] fill_ff;
   logic [lzsd_pkg::FILL_W-1:0] fill_in;
   logic                        fwd_in;
   logic                        zero_in;
   logic                        fill_full;

   assign fill_full = fill_ff[lzsd_pkg::FILL_W-1];

   // Writes go out in address order from zero, so the written set is a prefix
   always_comb begin
      fill_in = fill_ff;
      if (win_req.wr_en && !fill_full &&
          win_req.wr_addr == fill_ff[lzsd_pkg::WIN_AW-1:0]) begin
         fill_in = fill_ff + 1'b1;
      end
      fwd_in  = win_req.wr_en && (win_req.wr_addr == win_req.rd_addr);
      zero_in = !fill_full && (win_req.rd_addr >= fill_ff[lzsd_pkg::WIN_AW-1:0]);
   end

   // Memory array
   always_ff @(posedge clock) begin
      if (win_req.wr_en) begin
         mem_array[win_req.wr_addr] <= win_req.wr_data;
      end
      if (win_req.rd_en) begin
         rdata_ff    <= mem_array[win_req.rd_addr];
         fwd_data_ff <= win_req.wr_data;
      end
   end

   // Read qualifiers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (win_req.rd_en) begin
            fwd_ff  <= fwd_in;
            zero_ff <= zero_in;
         end
      end
   end

   // Forwarded byte wins; unwritten entries read as zero
   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (zero_ff) begin
         rd_data = 8'h00;
      end else begin
         rd_data = rdata_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lzsd_engine.sv =====
// ----------------------------------------------------------------------------
// lzsd_engine
// Token parser and copy sequencer: decodes flag, literal and token bytes,
// streams match bytes out of the window and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzsd_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lzsd_pkg::cfg_type          cfg,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // [7:0] in_byte
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,   // [0] limit_reached
   output lzsd_pkg::win_req_type           win_req,
   input  wire logic [7:0]                 win_rdata
);

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   state_type                      state_ff, state_in;
   logic [8:0]                     flag_ff, flag_in;
   logic                           phase_ff, phase_in;
   logic [7:0]                     first_ff, first_in;
   logic [lzsd_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           stopped_ff, stopped_in;
   logic [lzsd_pkg::RUN_W-1:0]     rem_ff, rem_in;
   logic                           pend_ff, pend_in;
   logic                           last_ff, last_in;
   logic [lzsd_pkg::WIN_AW-1:0]    src_ff, src_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_user_ff, rsp_user_in;

   logic                           out_free;
   logic                           accept;
   logic [15:0]                    tok;
   logic [lzsd_pkg::COUNT_W-1:0]   count_inc;
   logic                           lim_now;
   logic                           lim_next;
   logic                           emit;
   logic                           issue;
   logic                           restart;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign tok        = cfg.big_endian ? {first_ff, req_tdata} : {req_tdata, first_ff};
   assign count_inc  = count_ff + 1'b1;
   assign lim_now    = count_ff >= cfg.out_limit;
   assign lim_next   = count_inc == cfg.out_limit;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      phase_in     = phase_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      stopped_in   = stopped_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      src_in       = src_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      emit         = 1'b0;
      issue        = 1'b0;
      restart      = 1'b0;

      win_req         = '0;
      win_req.rd_addr = src_ff;
      win_req.wr_addr = count_ff[lzsd_pkg::WIN_AW-1:0];
      win_req.wr_data = req_tdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               restart = req_tlast;
               if (stopped_ff) begin
                  // rest of the stream is dropped
               end else if (flag_ff[8:1] == '0) begin
                  flag_in  = {1'b1, req_tdata};
                  phase_in = 1'b0;
               end else if (flag_ff[0]) begin
                  // literal
                  if (lim_now) begin
                     stopped_in = 1'b1;
                  end else begin
                     win_req.wr_en = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = req_tdata;
                     rsp_last_in   = 1'b1;
                     rsp_user_in   = lim_next;
                     count_in      = count_inc;
                     flag_in       = flag_ff >> 1;
                     phase_in      = 1'b0;
                  end
               end else if (!phase_ff) begin
                  first_in = req_tdata;
                  phase_in = 1'b1;
               end else begin
                  // second token byte: start a match run
                  flag_in  = flag_ff >> 1;
                  phase_in = 1'b0;
                  if (lim_now) begin
                     stopped_in = 1'b1;
                  end else begin
                     state_in = ST_COPY;
                     rem_in   = {1'b0, tok[15:12]} + lzsd_pkg::RUN_MIN;
                     src_in   = count_ff[lzsd_pkg::WIN_AW-1:0] + tok[11:0];
                     last_in  = req_tlast;
                     pend_in  = 1'b0;
                     restart  = 1'b0;
                  end
               end
            end
         end

         ST_COPY: begin
            emit  = pend_ff && out_free;
            issue = (rem_ff != '0) && (!pend_ff || emit) && !(emit && lim_next);

            // emit the pending window byte
            if (emit) begin
               win_req.wr_en   = 1'b1;
               win_req.wr_data = win_rdata;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = win_rdata;
               rsp_last_in     = (rem_ff == '0) || lim_next;
               rsp_user_in     = lim_next;
               count_in        = count_inc;
               pend_in         = 1'b0;
               if (rem_ff == '0 || lim_next) begin
                  // a cut-short run counts as a failed emit
                  stopped_in = lim_next && (rem_ff != '0);
                  state_in   = ST_IDLE;
                  restart    = last_ff;
               end
            end

            // fetch the next source byte
            if (issue) begin
               win_req.rd_en = 1'b1;
               src_in        = src_ff + 1'b1;
               rem_in        = rem_ff - 1'b1;
               pend_in       = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // stream end returns the parser to its start state
      if (restart) begin
         flag_in    = 9'h001;
         phase_in   = 1'b0;
         first_in   = 8'h00;
         count_in   = '0;
         stopped_in = 1'b0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= 9'h001;
         phase_ff     <= 1'b0;
         first_ff     <= 8'h00;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         stopped_ff   <= stopped_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZSS byte stream decompressor.
// Compressed streams go in through the request port, and a model of the
// decoder predicts every decompressed byte, its end-of-request mark and its
// limit flag. Each response is compared with the oldest prediction. Directed
// streams cover literals, both token byte orders, the output limit, stream
// ends in awkward places and a reach of the full window. Random streams then
// run under several register settings, with random gaps and stalls on both
// sides.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int          DRAIN_CYCLES = 40;     // covers the longest match plus margin
   localparam int          RANDOM_ITEMS = 64;
   localparam logic        FLAG_LITERAL = 1'b1;
   localparam logic [8:0]  FLAGS_EMPTY  = 9'h001;  // marker only: flag byte awaited
   localparam logic [lzsd_pkg::COUNT_W-1:0] LIMIT_MAX = '1;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       at_limit;
   } out_beat_type;

   // DUT connections
   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;   // [7:0] in_byte
   logic                           req_tlast;   // stream_last
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [7:0]                     rsp_tdata;   // [7:0] out_byte
   logic                           rsp_tlast;   // run_last
   logic                           rsp_tuser;   // [0] limit_reached
   logic                           csr_valid;
   logic                           csr_ready;
   logic [lzsd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lzsd_pkg::COUNT_W-1:0]   csr_wdata;

   // Decoder model state
   logic [7:0]                   win_mem [0:lzsd_pkg::WIN_SIZE-1];
   logic [8:0]                   flag_sr;
   logic                         token_half;
   logic [7:0]                   token_byte0;
   logic [lzsd_pkg::COUNT_W-1:0] out_count;
   logic                         halted;
   logic [lzsd_pkg::COUNT_W-1:0] cfg_out_limit;
   logic                         cfg_big_endian;

   // Predicted output bytes, oldest first
   out_beat_type exp_q [$];
   out_beat_type got_beat;
   out_beat_type want_beat;
   logic [7:0]   stream_bytes [$];

   int snd_max_gap   = 15;
   int rcv_max_stall = 15;
   int mismatch_count;
   int requests_sent;
   int results_checked;
   int streams_sent;
   int reg_writes;

   lzss_byte_stream_decompressor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   task automatic restart_stream;
      flag_sr     = FLAGS_EMPTY;
      token_half  = 1'b0;
      token_byte0 = 8'h00;
      out_count   = '0;
      halted      = 1'b0;
   endtask

   task automatic reset_model;
      for (int i = 0; i < lzsd_pkg::WIN_SIZE; i++) win_mem[i] = 8'h00;
      cfg_out_limit  = lzsd_pkg::LIMIT_RESET;
      cfg_big_endian = 1'b0;
      restart_stream();
   endtask

   // Writes one byte to the window and queues it, unless the limit stops it
   function automatic bit emit_byte(input logic [7:0] b);
      out_beat_type beat;
      if (halted || out_count >= cfg_out_limit) begin
         halted = 1'b1;
         return 1'b0;
      end
      win_mem[out_count[lzsd_pkg::WIN_AW-1:0]] = b;
      out_count     = out_count + 1'b1;
      beat.data     = b;
      beat.run_end  = 1'b0;
      beat.at_limit = (out_count == cfg_out_limit);
      exp_q.push_back(beat);
      return 1'b1;
   endfunction

   task automatic decode_request(input logic [7:0] b, input logic last);
      logic [15:0]                  tok;
      logic [12:0]                  back_dist;
      logic [lzsd_pkg::RUN_W-1:0]   len;
      logic [lzsd_pkg::WIN_AW-1:0]  src;
      logic [lzsd_pkg::COUNT_W-1:0] start_count;
      out_beat_type                 tail;
      start_count = out_count;
      if (halted) begin
         // rest of the stream is dropped
      end else if (flag_sr <= FLAGS_EMPTY) begin
         flag_sr    = {1'b1, b};
         token_half = 1'b0;
      end else if (flag_sr[0] == FLAG_LITERAL) begin
         if (emit_byte(b)) begin
            flag_sr    = flag_sr >> 1;
            token_half = 1'b0;
         end
      end else if (!token_half) begin
         token_byte0 = b;
         token_half  = 1'b1;
      end else begin
         tok       = cfg_big_endian ? {token_byte0, b} : {b, token_byte0};
         back_dist = 13'h1000 - {1'b0, tok[11:0]};
         len       = {1'b0, tok[15:12]} + lzsd_pkg::RUN_MIN;
         for (int i = 0; i < len; i++) begin
            src = out_count[lzsd_pkg::WIN_AW-1:0] - back_dist[lzsd_pkg::WIN_AW-1:0];
            if (!emit_byte(win_mem[src])) break;
         end
         flag_sr    = flag_sr >> 1;
         token_half = 1'b0;
      end
      // mark the final byte this request produced
      if (out_count != start_count) begin
         tail = exp_q.pop_back();
         tail.run_end = 1'b1;
         exp_q.push_back(tail);
      end
      if (last) restart_stream();
   endtask

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = $urandom_range(0, snd_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      decode_request(b, last);
   endtask

   task automatic send_stream(input int pause_at);
      for (int i = 0; i < stream_bytes.size(); i++) begin
         if (i == pause_at) wait_results();
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      end
      streams_sent++;
   endtask

   task automatic write_reg(input logic [lzsd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lzsd_pkg::COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lzsd_pkg::CSR_OUT_LIMIT:   cfg_out_limit  = value;
         lzsd_pkg::CSR_TOKEN_ORDER: cfg_big_endian = value[0];
         default: ;
      endcase
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sender holds off until every predicted byte has come out
   task automatic wait_results;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (exp_q.size() != 0);
   endtask

   task automatic wait_idle;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Token bytes in the order the current register setting expects
   task automatic push_token(input int back_dist, input int len);
      logic [15:0] tok;
      tok[15:12] = 4'(len - 3);
      tok[11:0]  = 12'(lzsd_pkg::WIN_SIZE - back_dist);
      if (cfg_big_endian) begin
         stream_bytes.push_back(tok[15:8]);
         stream_bytes.push_back(tok[7:0]);
      end else begin
         stream_bytes.push_back(tok[7:0]);
         stream_bytes.push_back(tok[15:8]);
      end
   endtask

   // Mostly well-formed groups, some noise and some cut short
   task automatic build_random_stream;
      int         kind;
      int         groups;
      int         back_dist;
      int         cut;
      logic [7:0] flags;
      stream_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(3, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      groups = $urandom_range(1, 2);
      repeat (groups) begin
         flags = 8'($urandom_range(0, 255));
         stream_bytes.push_back(flags);
         for (int k = 0; k < 8; k++) begin
            if (flags[k] == FLAG_LITERAL) begin
               stream_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               case ($urandom_range(0, 9))
                  0:       back_dist = lzsd_pkg::WIN_SIZE;
                  1, 2:    back_dist = $urandom_range(1, lzsd_pkg::WIN_SIZE);
                  default: back_dist = $urandom_range(1, 40);
               endcase
               push_token(back_dist, $urandom_range(3, 18));
            end
         end
      end
      if (kind <= 2) begin
         cut = $urandom_range(1, stream_bytes.size());
         while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls and the checker
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, rcv_max_stall);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat = '{data: rsp_tdata, run_end: rsp_tlast, at_limit: rsp_tuser};
         results_checked++;
         if (exp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: byte %02h last %0b limit %0b",
                        got_beat.data, got_beat.run_end, got_beat.at_limit);
         end else begin
            want_beat = exp_q.pop_front();
            if (got_beat !== want_beat) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at byte %0d: data %02h/%02h last %0b/%0b limit %0b/%0b",
                           results_checked, want_beat.data, got_beat.data,
                           want_beat.run_end, got_beat.run_end,
                           want_beat.at_limit, got_beat.at_limit);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_literals;
      stream_bytes = {8'hFF, 8'h00, 8'hFF, 8'hA5};
      send_stream(-1);
   endtask

   task automatic test_tokens_little_endian;
      // token, literal, token, token
      stream_bytes = {8'b0000_0010};
      push_token(lzsd_pkg::WIN_SIZE, 18);
      stream_bytes.push_back(8'h3C);
      push_token(1, 3);
      push_token(2, 10);
      send_stream(-1);
   endtask

   task automatic test_tokens_big_endian;
      wait_idle();
      write_reg(lzsd_pkg::CSR_TOKEN_ORDER, 24'd1);
      stream_bytes = {8'h04};
      push_token(2, 18);
      push_token(lzsd_pkg::WIN_SIZE, 3);
      stream_bytes.push_back(8'hC3);
      send_stream(-1);
   endtask

   task automatic test_output_limit;
      // zero limit: nothing comes out
      wait_idle();
      write_reg(lzsd_pkg::CSR_OUT_LIMIT, 24'd0);
      stream_bytes = {8'hFF, 8'h11, 8'h22};
      send_stream(-1);
      // a match cut short by the limit, then the rest ignored
      wait_idle();
      write_reg(lzsd_pkg::CSR_OUT_LIMIT, 24'd5);
      stream_bytes = {8'h05, 8'h77};
      push_token(1, 18);
      stream_bytes.push_back(8'h99);
      send_stream(-1);
   endtask

   task automatic test_stream_ends;
      wait_idle();
      write_reg(lzsd_pkg::CSR_OUT_LIMIT, lzsd_pkg::LIMIT_RESET);
      write_reg(lzsd_pkg::CSR_TOKEN_ORDER, 24'd0);
      // end on the first token byte, on a flag byte, then on a literal
      stream_bytes = {8'h00, 8'h12};
      send_stream(-1);
      stream_bytes = {8'hAA};
      send_stream(-1);
      stream_bytes = {8'h01, 8'h5E};
      send_stream(-1);
   endtask

   // Full-distance and long references into bytes of earlier streams
   task automatic test_full_window_reach;
      wait_idle();
      write_reg(lzsd_pkg::CSR_OUT_LIMIT, LIMIT_MAX);
      snd_max_gap   = 0;
      rcv_max_stall = 0;
      stream_bytes = {8'h00};
      push_token(lzsd_pkg::WIN_SIZE, 18);
      push_token(lzsd_pkg::WIN_SIZE - 1, 18);
      push_token(2048, 12);
      push_token(1, 3);
      send_stream(-1);
      snd_max_gap   = 15;
      rcv_max_stall = 15;
   endtask

   task automatic test_random_streams;
      int                           phase;
      int                           first_request;
      logic [lzsd_pkg::COUNT_W-1:0] limit;
      phase = 0;
      first_request = requests_sent;
      while (requests_sent - first_request < RANDOM_ITEMS) begin
         wait_idle();
         case (phase % 3)
            0:       limit = lzsd_pkg::LIMIT_RESET;
            1:       limit = 24'($urandom_range(1, 80));
            default: limit = LIMIT_MAX;
         endcase
         write_reg(lzsd_pkg::CSR_OUT_LIMIT, limit);
         write_reg(lzsd_pkg::CSR_TOKEN_ORDER, 24'(phase % 2));
         snd_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 15;
         rcv_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 15;
         build_random_stream();
         // first stream holds off half way until the output has drained
         send_stream(phase == 0 ? stream_bytes.size() / 2 : -1);
         phase++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_literals();
      test_tokens_little_endian();
      test_tokens_big_endian();
      test_output_limit();
      test_stream_ends();
      test_full_window_reach();
      test_random_streams();
      wait_idle();

      if (exp_q.size() != 0) begin
         mismatch_count++;
         $display("%0d predicted bytes never arrived", exp_q.size());
      end
      $display("summary: %0d requests in %0d streams, %0d register writes",
               requests_sent, streams_sent, reg_writes);
      $display("summary: %0d output bytes checked, %0d mismatches",
               results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
